@@ design/csray_pkg.sv @@
package csray_pkg;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;
    localparam logic [1:0] CFG_EPSILON  = 2'd3;

    localparam int SQRT_STEPS = 64;
    localparam int FRAC_BITS  = 25;
    localparam int NORM_BITS  = 31;

    typedef struct packed {
        logic [127:0] x;
        logic [66:0]  rem;
        logic [63:0]  root;
    } sqrt_t;

    typedef struct packed {
        logic [95:0] rem;
        logic [30:0] q;
    } div_t;

    // one digit of the integer square root, two radicand bits per step
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        logic [66:0] rem2;
        logic [66:0] trial;
        sqrt_t       r;
        rem2  = {s.rem[64:0], s.x[127:126]};
        trial = {1'b0, s.root, 2'b01};
        r.x   = {s.x[125:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[62:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[62:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of restoring division, quotient shifts in from the right
    function automatic div_t div_step(input div_t s, input logic [63:0] d,
                                      input logic [4:0] sh);
        logic [95:0] trial;
        div_t        r;
        trial = {32'd0, d} << sh;
        if (s.rem >= trial)
        begin
            r.rem = s.rem - trial;
            r.q   = {s.q[29:0], 1'b1};
        end
        else
        begin
            r.rem = s.rem;
            r.q   = {s.q[29:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ design/circle_segment_raycast_unit.sv @@
// Ray segment against a circle in fixed point. One item (body transform and ray
// segment) is taken in every clock cycle; busy stays low. Each item gives one
// result on the done strobe, in order; the pipeline depth is set by two 64-step
// square root pipelines and two restoring division pipelines (25 and 31 quotient
// bits), one step per stage. The receiver cannot hold results off. The
// configuration port is always ready; circle and epsilon registers are read by
// the pipeline stages, so write them only while no item is in flight.
module circle_segment_raycast_unit
    import csray_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] rot_cos,
    input  logic signed [31:0] rot_sin,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic [24:0]        limit_fraction,
    output logic               done,
    output logic               hit,
    output logic [24:0]        hit_fraction,
    output logic signed [31:0] normal_x,
    output logic signed [31:0] normal_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
    localparam logic signed [37:0] SAT_HI = (38'sd1 <<< (SAT_W - 1)) - 38'sd1;
    localparam logic signed [37:0] SAT_LO = -SAT_HI - 38'sd1;
    localparam int LAT = 8 + (SQRT_STEPS + 1) + 1 + (FRAC_BITS + 1) + 5
                       + (SQRT_STEPS + 1) + (NORM_BITS + 1) + 1;

    typedef struct packed {
        logic signed [64:0] negc;
        logic [63:0]        rr;
        logic [89:0]        lfrr;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               miss;
    } side_a_t;

    typedef struct packed {
        logic [63:0]        rr;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               miss;
    } side_b_t;

    typedef struct packed {
        logic signed [59:0] nx;
        logic signed [59:0] ny;
        logic [58:0]        mx;
        logic [58:0]        my;
        logic [24:0]        frac;
        logic               miss;
    } side_c_t;

    typedef struct packed {
        logic [63:0] len;
        logic        neg_x;
        logic        neg_y;
        logic        shortn;
        logic [31:0] short_x;
        logic [31:0] short_y;
        logic [24:0] frac;
        logic        miss;
    } side_d_t;

    function automatic logic signed [31:0] sat_coord(input logic signed [37:0] v);
        logic signed [37:0] c;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return c[31:0];
    endfunction

    // configuration registers
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [30:0]        radius_reg;
    logic [15:0]        epsilon_reg;

    logic [LAT-1:0] vld_reg;

    // front stages
    logic signed [63:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic [24:0]        s1_lf_reg, s2_lf_reg, s3_lf_reg, s4_lf_reg, s5_lf_reg, s6_lf_reg;
    logic signed [35:0] cwx_reg, cwy_reg;
    logic signed [31:0] s2_ax_reg, s2_ay_reg, s2_rx_reg, s2_ry_reg;
    logic signed [31:0] s3_sx_reg, s3_sy_reg, s3_rx_reg, s3_ry_reg;
    logic signed [31:0] s4_sx_reg, s4_sy_reg, s4_rx_reg, s4_ry_reg;
    logic signed [63:0] rxrx_reg, ryry_reg, sxry_reg, syrx_reg, sxrx_reg, syry_reg;
    logic [61:0]        r2_reg, s5_r2_reg, s6_r2_reg;
    logic [63:0]        rr_next, s5_rr_reg, s6_rr_reg, s7_rr_reg, s8_rr_reg;
    logic signed [64:0] cross_reg, s5_negc_reg, s6_negc_reg, s7_negc_reg, s8_negc_reg;
    logic               short_next, s5_short_reg, s6_short_reg, s7_short_reg, s8_short_reg;
    logic signed [31:0] s5_sx_reg, s5_sy_reg, s5_rx_reg, s5_ry_reg;
    logic signed [31:0] s6_sx_reg, s6_sy_reg, s6_rx_reg, s6_ry_reg;
    logic signed [31:0] s7_sx_reg, s7_sy_reg, s7_rx_reg, s7_ry_reg;
    logic signed [31:0] s8_sx_reg, s8_sy_reg, s8_rx_reg, s8_ry_reg;
    logic [63:0]        magc_reg;
    logic [63:0]        c_hh_reg, c_hl_reg, c_ll_reg, t_hl_reg, t_ll_reg;
    logic [61:0]        t_hh_reg, t_lh_reg;
    logic [56:0]        l_h_reg, l_l_reg;
    logic [127:0]       cc_reg, rrr2_reg;
    logic [89:0]        lfrr_reg;

    // discriminant root
    sqrt_t   sq1_reg [0:SQRT_STEPS];
    side_a_t sa_reg  [0:SQRT_STEPS];

    // root and limit check
    logic [63:0]        a_reg;
    logic               s10_miss_reg;
    logic [63:0]        s10_rr_reg;
    logic [89:0]        s10_lfrr_reg;
    logic signed [31:0] s10_sx_reg, s10_sy_reg, s10_rx_reg, s10_ry_reg;
    logic signed [64:0] sq1_root_s;
    logic [79:0]        num_s;

    // fraction divider
    div_t    dv1_reg [0:FRAC_BITS];
    side_b_t sb_reg  [0:FRAC_BITS];

    // hit point vector
    logic [24:0]        frac_s;
    logic signed [57:0] fx_reg, fy_reg;
    logic signed [31:0] p1_sx_reg, p1_sy_reg;
    logic [24:0]        p1_frac_reg, p2_frac_reg, p3_frac_reg, p4_frac_reg, p5_frac_reg;
    logic               p1_miss_reg, p2_miss_reg, p3_miss_reg, p4_miss_reg, p5_miss_reg;
    logic signed [59:0] nx_reg, ny_reg, p3_nx_reg, p3_ny_reg, p4_nx_reg, p4_ny_reg;
    logic signed [59:0] p5_nx_reg, p5_ny_reg;
    logic [58:0]        mx_reg, my_reg, p4_mx_reg, p4_my_reg, p5_mx_reg, p5_my_reg;
    logic [53:0]        x_hh_reg, y_hh_reg;
    logic [58:0]        x_hl_reg, y_hl_reg;
    logic [63:0]        x_ll_reg, y_ll_reg;
    logic [127:0]       xsq_reg, ysq_reg;

    // normal length root
    sqrt_t   sq2_reg [0:SQRT_STEPS];
    side_c_t sc_reg  [0:SQRT_STEPS];

    // normal dividers
    logic [63:0] len_s;
    div_t    dvx_reg [0:NORM_BITS];
    div_t    dvy_reg [0:NORM_BITS];
    side_d_t sd_reg  [0:NORM_BITS];

    logic               hit_reg;
    logic [24:0]        frac_out_reg;
    logic signed [31:0] normal_x_reg, normal_y_reg;
    side_d_t            fin_s;
    logic [30:0]        qx_s, qy_s;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= 32'sd0;
            center_y_reg <= 32'sd0;
            radius_reg   <= 31'd65536;
            epsilon_reg  <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[30:0];
                CFG_EPSILON:  epsilon_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start && !busy};
    end

    always_comb
    begin
        rr_next    = 64'(rxrx_reg) + 64'(ryry_reg);
        short_next = (rr_next == 64'd0) || (rr_next < 64'({epsilon_reg, 16'd0}));
    end

    always_ff @(posedge clk)
    begin
        // rotate the center
        p_xc_reg  <= rot_cos * center_x_reg;
        p_ys_reg  <= rot_sin * center_y_reg;
        p_xs_reg  <= rot_sin * center_x_reg;
        p_yc_reg  <= rot_cos * center_y_reg;
        s1_px_reg <= pos_x;
        s1_py_reg <= pos_y;
        s1_ax_reg <= start_x;
        s1_ay_reg <= start_y;
        s1_bx_reg <= end_x;
        s1_by_reg <= end_y;
        s1_lf_reg <= limit_fraction;

        cwx_reg   <= 36'(s1_px_reg) + 36'(p_xc_reg >>> 30) - 36'(p_ys_reg >>> 30);
        cwy_reg   <= 36'(s1_py_reg) + 36'(p_xs_reg >>> 30) + 36'(p_yc_reg >>> 30);
        s2_rx_reg <= sat_coord(38'(s1_bx_reg) - 38'(s1_ax_reg));
        s2_ry_reg <= sat_coord(38'(s1_by_reg) - 38'(s1_ay_reg));
        s2_ax_reg <= s1_ax_reg;
        s2_ay_reg <= s1_ay_reg;
        s2_lf_reg <= s1_lf_reg;

        s3_sx_reg <= sat_coord(38'(s2_ax_reg) - 38'(cwx_reg));
        s3_sy_reg <= sat_coord(38'(s2_ay_reg) - 38'(cwy_reg));
        s3_rx_reg <= s2_rx_reg;
        s3_ry_reg <= s2_ry_reg;
        s3_lf_reg <= s2_lf_reg;

        rxrx_reg  <= s3_rx_reg * s3_rx_reg;
        ryry_reg  <= s3_ry_reg * s3_ry_reg;
        sxry_reg  <= s3_sx_reg * s3_ry_reg;
        syrx_reg  <= s3_sy_reg * s3_rx_reg;
        sxrx_reg  <= s3_sx_reg * s3_rx_reg;
        syry_reg  <= s3_sy_reg * s3_ry_reg;
        r2_reg    <= radius_reg * radius_reg;
        s4_sx_reg <= s3_sx_reg;
        s4_sy_reg <= s3_sy_reg;
        s4_rx_reg <= s3_rx_reg;
        s4_ry_reg <= s3_ry_reg;
        s4_lf_reg <= s3_lf_reg;

        s5_rr_reg    <= rr_next;
        s5_short_reg <= short_next;
        cross_reg    <= 65'(sxry_reg) - 65'(syrx_reg);
        s5_negc_reg  <= -(65'(sxrx_reg) + 65'(syry_reg));
        s5_r2_reg    <= r2_reg;
        s5_sx_reg    <= s4_sx_reg;
        s5_sy_reg    <= s4_sy_reg;
        s5_rx_reg    <= s4_rx_reg;
        s5_ry_reg    <= s4_ry_reg;
        s5_lf_reg    <= s4_lf_reg;

        magc_reg     <= cross_reg[64] ? 64'(-cross_reg) : 64'(cross_reg);
        s6_rr_reg    <= s5_rr_reg;
        s6_short_reg <= s5_short_reg;
        s6_negc_reg  <= s5_negc_reg;
        s6_r2_reg    <= s5_r2_reg;
        s6_sx_reg    <= s5_sx_reg;
        s6_sy_reg    <= s5_sy_reg;
        s6_rx_reg    <= s5_rx_reg;
        s6_ry_reg    <= s5_ry_reg;
        s6_lf_reg    <= s5_lf_reg;

        // split wide products into 32-bit partials
        c_hh_reg     <= magc_reg[63:32] * magc_reg[63:32];
        c_hl_reg     <= magc_reg[63:32] * magc_reg[31:0];
        c_ll_reg     <= magc_reg[31:0] * magc_reg[31:0];
        t_hh_reg     <= s6_rr_reg[63:32] * s6_r2_reg[61:32];
        t_hl_reg     <= s6_rr_reg[63:32] * s6_r2_reg[31:0];
        t_lh_reg     <= s6_rr_reg[31:0] * s6_r2_reg[61:32];
        t_ll_reg     <= s6_rr_reg[31:0] * s6_r2_reg[31:0];
        l_h_reg      <= s6_lf_reg * s6_rr_reg[63:32];
        l_l_reg      <= s6_lf_reg * s6_rr_reg[31:0];
        s7_rr_reg    <= s6_rr_reg;
        s7_short_reg <= s6_short_reg;
        s7_negc_reg  <= s6_negc_reg;
        s7_sx_reg    <= s6_sx_reg;
        s7_sy_reg    <= s6_sy_reg;
        s7_rx_reg    <= s6_rx_reg;
        s7_ry_reg    <= s6_ry_reg;

        cc_reg       <= (128'(c_hh_reg) << 64) + (128'(c_hl_reg) << 33) + 128'(c_ll_reg);
        rrr2_reg     <= (128'(t_hh_reg) << 64) + (128'(t_hl_reg) << 32)
                      + (128'(t_lh_reg) << 32) + 128'(t_ll_reg);
        lfrr_reg     <= (90'(l_h_reg) << 32) + 90'(l_l_reg);
        s8_rr_reg    <= s7_rr_reg;
        s8_short_reg <= s7_short_reg;
        s8_negc_reg  <= s7_negc_reg;
        s8_sx_reg    <= s7_sx_reg;
        s8_sy_reg    <= s7_sy_reg;
        s8_rx_reg    <= s7_rx_reg;
        s8_ry_reg    <= s7_ry_reg;

        // discriminant into the root pipeline
        sq1_reg[0].x    <= rrr2_reg - cc_reg;
        sq1_reg[0].rem  <= '0;
        sq1_reg[0].root <= '0;
        sa_reg[0].negc  <= s8_negc_reg;
        sa_reg[0].rr    <= s8_rr_reg;
        sa_reg[0].lfrr  <= lfrr_reg;
        sa_reg[0].sx    <= s8_sx_reg;
        sa_reg[0].sy    <= s8_sy_reg;
        sa_reg[0].rx    <= s8_rx_reg;
        sa_reg[0].ry    <= s8_ry_reg;
        sa_reg[0].miss  <= s8_short_reg || (cc_reg > rrr2_reg);
    end

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_sq1
        always_ff @(posedge clk)
        begin
            sq1_reg[k+1] <= sqrt_step(sq1_reg[k]);
            sa_reg[k+1]  <= sa_reg[k];
        end
    end

    assign sq1_root_s = $signed({1'b0, sq1_reg[SQRT_STEPS].root});
    assign num_s      = {a_reg, 16'd0};

    always_ff @(posedge clk)
    begin
        a_reg        <= 64'(sa_reg[SQRT_STEPS].negc - sq1_root_s);
        s10_miss_reg <= sa_reg[SQRT_STEPS].miss || sa_reg[SQRT_STEPS].negc[64]
                     || (sq1_root_s > sa_reg[SQRT_STEPS].negc);
        s10_rr_reg   <= sa_reg[SQRT_STEPS].rr;
        s10_lfrr_reg <= sa_reg[SQRT_STEPS].lfrr;
        s10_sx_reg   <= sa_reg[SQRT_STEPS].sx;
        s10_sy_reg   <= sa_reg[SQRT_STEPS].sy;
        s10_rx_reg   <= sa_reg[SQRT_STEPS].rx;
        s10_ry_reg   <= sa_reg[SQRT_STEPS].ry;

        dv1_reg[0].rem <= 96'(num_s);
        dv1_reg[0].q   <= '0;
        sb_reg[0].rr   <= s10_rr_reg;
        sb_reg[0].sx   <= s10_sx_reg;
        sb_reg[0].sy   <= s10_sy_reg;
        sb_reg[0].rx   <= s10_rx_reg;
        sb_reg[0].ry   <= s10_ry_reg;
        sb_reg[0].miss <= s10_miss_reg || ({10'd0, num_s} > s10_lfrr_reg);
    end

    for (k = 0; k < FRAC_BITS; k++)
    begin : g_dv1
        always_ff @(posedge clk)
        begin
            dv1_reg[k+1] <= div_step(dv1_reg[k], sb_reg[k].rr, 5'(FRAC_BITS - 1 - k));
            sb_reg[k+1]  <= sb_reg[k];
        end
    end

    assign frac_s = dv1_reg[FRAC_BITS].q[24:0];

    always_ff @(posedge clk)
    begin
        fx_reg      <= $signed({1'b0, frac_s}) * sb_reg[FRAC_BITS].rx;
        fy_reg      <= $signed({1'b0, frac_s}) * sb_reg[FRAC_BITS].ry;
        p1_sx_reg   <= sb_reg[FRAC_BITS].sx;
        p1_sy_reg   <= sb_reg[FRAC_BITS].sy;
        p1_frac_reg <= frac_s;
        p1_miss_reg <= sb_reg[FRAC_BITS].miss;

        nx_reg      <= (60'(p1_sx_reg) <<< 16) + 60'(fx_reg);
        ny_reg      <= (60'(p1_sy_reg) <<< 16) + 60'(fy_reg);
        p2_frac_reg <= p1_frac_reg;
        p2_miss_reg <= p1_miss_reg;

        mx_reg      <= nx_reg[59] ? 59'(-nx_reg) : 59'(nx_reg);
        my_reg      <= ny_reg[59] ? 59'(-ny_reg) : 59'(ny_reg);
        p3_nx_reg   <= nx_reg;
        p3_ny_reg   <= ny_reg;
        p3_frac_reg <= p2_frac_reg;
        p3_miss_reg <= p2_miss_reg;

        x_hh_reg    <= mx_reg[58:32] * mx_reg[58:32];
        x_hl_reg    <= mx_reg[58:32] * mx_reg[31:0];
        x_ll_reg    <= mx_reg[31:0] * mx_reg[31:0];
        y_hh_reg    <= my_reg[58:32] * my_reg[58:32];
        y_hl_reg    <= my_reg[58:32] * my_reg[31:0];
        y_ll_reg    <= my_reg[31:0] * my_reg[31:0];
        p4_nx_reg   <= p3_nx_reg;
        p4_ny_reg   <= p3_ny_reg;
        p4_mx_reg   <= mx_reg;
        p4_my_reg   <= my_reg;
        p4_frac_reg <= p3_frac_reg;
        p4_miss_reg <= p3_miss_reg;

        xsq_reg     <= (128'(x_hh_reg) << 64) + (128'(x_hl_reg) << 33) + 128'(x_ll_reg);
        ysq_reg     <= (128'(y_hh_reg) << 64) + (128'(y_hl_reg) << 33) + 128'(y_ll_reg);
        p5_nx_reg   <= p4_nx_reg;
        p5_ny_reg   <= p4_ny_reg;
        p5_mx_reg   <= p4_mx_reg;
        p5_my_reg   <= p4_my_reg;
        p5_frac_reg <= p4_frac_reg;
        p5_miss_reg <= p4_miss_reg;

        sq2_reg[0].x    <= xsq_reg + ysq_reg;
        sq2_reg[0].rem  <= '0;
        sq2_reg[0].root <= '0;
        sc_reg[0].nx    <= p5_nx_reg;
        sc_reg[0].ny    <= p5_ny_reg;
        sc_reg[0].mx    <= p5_mx_reg;
        sc_reg[0].my    <= p5_my_reg;
        sc_reg[0].frac  <= p5_frac_reg;
        sc_reg[0].miss  <= p5_miss_reg;
    end

    for (k = 0; k < SQRT_STEPS; k++)
    begin : g_sq2
        always_ff @(posedge clk)
        begin
            sq2_reg[k+1] <= sqrt_step(sq2_reg[k]);
            sc_reg[k+1]  <= sc_reg[k];
        end
    end

    assign len_s = sq2_reg[SQRT_STEPS].root;

    always_ff @(posedge clk)
    begin
        dvx_reg[0].rem    <= 96'({sc_reg[SQRT_STEPS].mx, 30'd0});
        dvx_reg[0].q      <= '0;
        dvy_reg[0].rem    <= 96'({sc_reg[SQRT_STEPS].my, 30'd0});
        dvy_reg[0].q      <= '0;
        sd_reg[0].len     <= len_s;
        sd_reg[0].neg_x   <= sc_reg[SQRT_STEPS].nx[59];
        sd_reg[0].neg_y   <= sc_reg[SQRT_STEPS].ny[59];
        sd_reg[0].shortn  <= (len_s == 64'd0) || (len_s < 64'({epsilon_reg, 16'd0}));
        sd_reg[0].short_x <= sc_reg[SQRT_STEPS].nx[33:2];
        sd_reg[0].short_y <= sc_reg[SQRT_STEPS].ny[33:2];
        sd_reg[0].frac    <= sc_reg[SQRT_STEPS].frac;
        sd_reg[0].miss    <= sc_reg[SQRT_STEPS].miss;
    end

    for (k = 0; k < NORM_BITS; k++)
    begin : g_dv2
        always_ff @(posedge clk)
        begin
            dvx_reg[k+1] <= div_step(dvx_reg[k], sd_reg[k].len, 5'(NORM_BITS - 1 - k));
            dvy_reg[k+1] <= div_step(dvy_reg[k], sd_reg[k].len, 5'(NORM_BITS - 1 - k));
            sd_reg[k+1]  <= sd_reg[k];
        end
    end

    assign fin_s = sd_reg[NORM_BITS];
    assign qx_s  = dvx_reg[NORM_BITS].q;
    assign qy_s  = dvy_reg[NORM_BITS].q;

    always_ff @(posedge clk)
    begin
        hit_reg      <= !fin_s.miss;
        frac_out_reg <= fin_s.miss ? 25'd0 : fin_s.frac;
        if (fin_s.miss)
        begin
            normal_x_reg <= 32'sd0;
            normal_y_reg <= 32'sd0;
        end
        else if (fin_s.shortn)
        begin
            normal_x_reg <= fin_s.short_x;
            normal_y_reg <= fin_s.short_y;
        end
        else
        begin
            normal_x_reg <= fin_s.neg_x ? 32'd0 - {1'b0, qx_s} : {1'b0, qx_s};
            normal_y_reg <= fin_s.neg_y ? 32'd0 - {1'b0, qy_s} : {1'b0, qy_s};
        end
    end

    assign done         = vld_reg[LAT-1];
    assign hit          = hit_reg;
    assign hit_fraction = frac_out_reg;
    assign normal_x     = normal_x_reg;
    assign normal_y     = normal_y_reg;

`ifndef SYNTHESIS
    a_item_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item gave no result");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted item");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_fraction == 25'd0 && normal_x == 32'sd0
                            && normal_y == 32'sd0))
        else $error("miss with nonzero fields");
`endif

endmodule

@@ tb/csray_checker.sv @@
`timescale 1ns / 1ps

module csray_checker
    import csray_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] rot_cos,
    input  logic signed [31:0] rot_sin,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic [24:0]        limit_fraction,
    input  logic               done,
    input  logic               hit,
    input  logic [24:0]        hit_fraction,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending,
    output int                 rays_seen,
    output int                 hits_seen
);

    typedef struct packed {
        logic        hit;
        logic [24:0] frac;
        logic [31:0] nx;
        logic [31:0] ny;
    } ray_result_t;

    logic signed [31:0] circ_cx;
    logic signed [31:0] circ_cy;
    logic [30:0]        circ_r;
    logic [15:0]        circ_eps;

    ray_result_t hit_queue[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root128(input logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic logic [127:0] abs128(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic ray_result_t cast_ray(
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] cs, input logic signed [31:0] sn,
        input logic signed [31:0] ax, input logic signed [31:0] ay,
        input logic signed [31:0] bx, input logic signed [31:0] by,
        input logic [24:0] lf);
        longint              cwx, cwy;
        logic signed [127:0] sx, sy, rx, ry, crs, negc, fw, nx, ny, qn;
        logic [63:0]         rr, sq, len;
        logic [127:0]        rrr2, cc, num, frac, lim, thr;
        logic                shortn;
        ray_result_t         res;
        res = '0;
        cwx = longint'(px) + ((longint'(cs) * longint'(circ_cx)) >>> 30)
              - ((longint'(sn) * longint'(circ_cy)) >>> 30);
        cwy = longint'(py) + ((longint'(sn) * longint'(circ_cx)) >>> 30)
              + ((longint'(cs) * longint'(circ_cy)) >>> 30);
        sx = clamp32(longint'(ax) - cwx);
        sy = clamp32(longint'(ay) - cwy);
        rx = clamp32(longint'(bx) - longint'(ax));
        ry = clamp32(longint'(by) - longint'(ay));
        rr = 64'(rx * rx) + 64'(ry * ry);
        thr = {96'd0, circ_eps, 16'd0};
        if (rr == 0 || {64'd0, rr} < thr)
            return res;
        crs  = sx * ry - sy * rx;
        negc = -(sx * rx) - sy * ry;
        rrr2 = {64'd0, rr} * ({97'd0, circ_r} * {97'd0, circ_r});
        cc   = abs128(crs) * abs128(crs);
        if (cc > rrr2)
            return res;
        sq = root128(rrr2 - cc);
        if (negc < 0 || $signed({64'd0, sq}) > negc)
            return res;
        num = (negc - $signed({64'd0, sq})) << 16;
        lim = {103'd0, lf} * {64'd0, rr};
        if (num > lim)
            return res;
        frac = num / {64'd0, rr};
        fw   = $signed(frac);
        nx   = sx * 65536 + fw * rx;
        ny   = sy * 65536 + fw * ry;
        len  = root128(abs128(nx) * abs128(nx) + abs128(ny) * abs128(ny));
        shortn = len == 0 || {64'd0, len} < thr;
        res.hit  = 1'b1;
        res.frac = frac[24:0];
        if (shortn)
        begin
            res.nx = 32'(nx >>> 2);
            res.ny = 32'(ny >>> 2);
        end
        else
        begin
            qn = $signed((abs128(nx) << 30) / {64'd0, len});
            res.nx = 32'(nx < 0 ? -qn : qn);
            qn = $signed((abs128(ny) << 30) / {64'd0, len});
            res.ny = 32'(ny < 0 ? -qn : qn);
        end
        return res;
    endfunction

    assign pending = hit_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_cx  <= '0;
            circ_cy  <= '0;
            circ_r   <= 31'd65536;
            circ_eps <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CENTER_X: circ_cx  <= cfg_data;
                CFG_CENTER_Y: circ_cy  <= cfg_data;
                CFG_RADIUS:   circ_r   <= cfg_data[30:0];
                CFG_EPSILON:  circ_eps <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    initial
    begin
        errors    = 0;
        rays_seen = 0;
        hits_seen = 0;
    end

    always @(posedge clk)
    begin
        ray_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (hit_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no item pending", $realtime);
                end
                else
                begin
                    want = hit_queue.pop_front();
                    if (hit !== want.hit || hit_fraction !== want.frac
                        || normal_x !== want.nx || normal_y !== want.ny)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch exp hit=%0d frac=%h nx=%h ny=%h",
                                     $realtime, want.hit, want.frac, want.nx, want.ny);
                            $display("%0t:          got hit=%0d frac=%h nx=%h ny=%h",
                                     $realtime, hit, hit_fraction, normal_x, normal_y);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = cast_ray(pos_x, pos_y, rot_cos, rot_sin, start_x, start_y,
                                end_x, end_y, limit_fraction);
                hit_queue.push_back(want);
                rays_seen++;
                if (want.hit)
                    hits_seen++;
            end
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import csray_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [24:0]        limit_fraction;
    logic               done;
    logic               hit;
    logic [24:0]        hit_fraction;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    int errors;
    int pending;
    int rays_seen;
    int hits_seen;
    int idle_cycles;

    longint cur_cx;
    longint cur_cy;
    longint cur_r;

    circle_segment_raycast_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .rot_cos        (rot_cos),
        .rot_sin        (rot_sin),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .limit_fraction (limit_fraction),
        .done           (done),
        .hit            (hit),
        .hit_fraction   (hit_fraction),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    csray_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .rot_cos        (rot_cos),
        .rot_sin        (rot_sin),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .limit_fraction (limit_fraction),
        .done           (done),
        .hit            (hit),
        .hit_fraction   (hit_fraction),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .rays_seen      (rays_seen),
        .hits_seen      (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[circle_segment_raycast_unit] ERROR");
            $finish;
        end
    end

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic pause_sender();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return;
        start <= 1'b0;
        if (sel < 90)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic send_ray(input longint px, input longint py, input longint cs,
                            input longint sn, input longint ax, input longint ay,
                            input longint bx, input longint by, input longint lf);
        pause_sender();
        start          <= 1'b1;
        pos_x          <= 32'(px);
        pos_y          <= 32'(py);
        rot_cos        <= 32'(cs);
        rot_sin        <= 32'(sn);
        start_x        <= 32'(ax);
        start_y        <= 32'(ay);
        end_x          <= 32'(bx);
        end_y          <= 32'(by);
        limit_fraction <= 25'(lf);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (210) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_circle(input longint cx, input longint cy, input longint r,
                              input longint eps);
        write_reg(CFG_CENTER_X, 32'(cx));
        write_reg(CFG_CENTER_Y, 32'(cy));
        write_reg(CFG_RADIUS, 32'(r));
        write_reg(CFG_EPSILON, 32'(eps));
        cur_cx = cx;
        cur_cy = cy;
        cur_r  = r;
    endtask

    task automatic random_ray();
        longint px, py, cs, sn, wx, wy, span, dx, dy, ax, ay, bx, by, lf;
        int     a;
        if ($urandom_range(0, 99) < 20)
        begin
            send_ray(int'($urandom), int'($urandom), rand_signed(1073741824),
                     rand_signed(1073741824), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom), $urandom_range(0, 16777216));
            return;
        end
        px = rand_signed(1 << 24);
        py = rand_signed(1 << 24);
        a  = $urandom_range(0, 8);
        case (a)
            0: begin cs = 1073741824;  sn = 0;           end
            1: begin cs = 0;           sn = 1073741824;  end
            2: begin cs = -1073741824; sn = 0;           end
            3: begin cs = 0;           sn = -1073741824; end
            4: begin cs = 759250125;   sn = 759250125;   end
            5: begin cs = -759250125;  sn = 759250125;   end
            6: begin cs = 929887697;   sn = -536870912;  end
            7: begin cs = 536870912;   sn = 929887697;   end
            default: begin cs = rand_signed(1073741824); sn = rand_signed(1073741824); end
        endcase
        wx = px + ((cs * cur_cx) >>> 30) - ((sn * cur_cy) >>> 30);
        wy = py + ((sn * cur_cx) >>> 30) + ((cs * cur_cy) >>> 30);
        span = cur_r > (1 << 26) ? (1 << 26) : cur_r;
        if (span < 4096)
            span = 65536;
        dx = rand_signed(int'(3 * span));
        dy = rand_signed(int'(3 * span));
        ax = sat_word(wx + dx);
        ay = sat_word(wy + dy);
        bx = sat_word(wx - dx + rand_signed(int'(span)));
        by = sat_word(wy - dy + rand_signed(int'(span)));
        if ($urandom_range(0, 9) < 7)
            lf = $urandom_range(65536, 16777216);
        else
            lf = $urandom_range(0, 65536);
        send_ray(px, py, cs, sn, ax, ay, bx, by, lf);
    endtask

    initial
    begin
        longint one;
        longint phase_cfg[6][4];
        one = 65536;
        rst_n          = 1'b0;
        start          = 1'b0;
        pos_x          = '0;
        pos_y          = '0;
        rot_cos        = '0;
        rot_sin        = '0;
        start_x        = '0;
        start_y        = '0;
        end_x          = '0;
        end_y          = '0;
        limit_fraction = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_cycles    = 0;
        cur_cx = 0;
        cur_cy = 0;
        cur_r  = 65536;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset circle: unit radius at the origin
        send_ray(0, 0, 1 << 30, 0, -2 * one, 0, 2 * one, 0, one);
        send_ray(0, 0, 1 << 30, 0, one, one, one, one, one);
        send_ray(0, 0, 1 << 30, 0, -2 * one, 5 * one, 2 * one, 5 * one, one);
        send_ray(0, 0, 1 << 30, 0, 2 * one, 0, 4 * one, 0, one);
        send_ray(0, 0, 1 << 30, 0, -2 * one, 0, 2 * one, 0, 0);
        send_ray(0, 0, 1 << 30, 0, 0, 0, 2 * one, 0, one);
        send_ray(0, 0, 1 << 30, 0, -2 * one, one, 2 * one, one, one);
        send_ray(3 * one, -one, 0, 1 << 30, 3 * one, -4 * one, 3 * one, 4 * one,
                 16777216);
        send_ray(0, 0, -(1 << 30), 0, -2 * one, -one / 2, 2 * one, one / 2, one / 2);
        send_ray(2147483647, 2147483647, 1 << 30, 1 << 30, 2147483647, 2147483647,
                 -2147483648, -2147483648, 16777216);
        send_ray(-2147483648, -2147483648, -(1 << 30), -(1 << 30), -2147483648,
                 -2147483648, 2147483647, 2147483647, 16777216);
        send_ray(-1, -1, 1 << 30, -(1 << 30), -2147483648, 2147483647,
                 2147483647, -2147483648, 0);
        send_ray(0, 0, 1 << 30, 0, 5, 0, 5, 0, one);
        drain();

        // zero radius and widest epsilon: hit right on the center, normal too short
        set_circle(0, 0, 0, 65535);
        send_ray(0, 0, 1 << 30, 0, -2 * one, 0, 2 * one, 0, one);
        send_ray(0, 0, 1 << 30, 0, 0, 0, 100, 0, one);
        send_ray(0, 0, 1 << 30, 0, -2 * one, one, 2 * one, one, one);
        drain();
        set_circle(0, 0, 1, 0);
        send_ray(0, 0, 1 << 30, 0, -2 * one, 0, 2 * one, 0, one);
        send_ray(0, 0, 1 << 30, 0, -1, 0, 1, 0, 16777216);
        drain();

        phase_cfg = '{
            '{0, 0, 65536, 1},
            '{100000, -50000, 200000, 0},
            '{2147483647, -2147483648, 2147483647, 65535},
            '{-300000, 1234567, 0, 0},
            '{-2147483648, 2147483647, 3, 65535},
            '{7 * 65536, -3 * 65536, 40 * 65536, 300}
        };
        foreach (phase_cfg[p])
        begin
            set_circle(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                       phase_cfg[p][3]);
            repeat (300) random_ray();
            drain();
        end

        $display("rays: %0d (%0d hits, %0d misses), over %0d circle settings",
                 rays_seen, hits_seen, rays_seen - hits_seen, 9);
        if (errors == 0 && pending == 0)
            $display("[circle_segment_raycast_unit] OK");
        else
            $display("[circle_segment_raycast_unit] ERROR");
        $finish;
    end

endmodule

@@ circle_segment_raycast_unit.f @@
design/csray_pkg.sv
design/circle_segment_raycast_unit.sv
tb/csray_checker.sv
tb/tb.sv
